>>> rtl/i6t_pkg.sv
package i6t_pkg;

  // address layout
  localparam int GROUPS     = 8;
  localparam int GROUP_BITS = 16;
  localparam int NIBBLES    = 4;

  // ascii codes used in the text form
  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DIGITS,
    ST_COLON,
    ST_DCOLON
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_DIGIT,
    EMIT_COLON
  } emit_t;

  typedef enum logic [2:0] {
    STEP_HOLD,
    STEP_FIRST,
    STEP_DIGIT,
    STEP_GROUP,
    STEP_SKIP
  } step_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  search;
    emit_t emit;
    logic  last;
    step_t step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic at_run;
    logic last_digit;
    logic need_colon;
    logic final_group;
    logic run_to_end;
  } status_t;

  // lower-case hex character for one nibble
  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    if (d >= 4'd10) begin
      c = CHAR_A + {3'b000, d} - 7'd10;
    end else begin
      c = CHAR_ZERO + {3'b000, d};
    end
    return c;
  endfunction

  // index of the leading non-zero nibble, zero for a zero group
  function automatic logic [1:0] lead_digit(input logic [GROUP_BITS-1:0] v);
    logic [1:0] idx;
    if (v[15:12] != 4'd0) begin
      idx = 2'd3;
    end else if (v[11:8] != 4'd0) begin
      idx = 2'd2;
    end else if (v[7:4] != 4'd0) begin
      idx = 2'd1;
    end else begin
      idx = 2'd0;
    end
    return idx;
  endfunction

endpackage

>>> rtl/i6t_addr_if.sv
interface i6t_addr_if;
  logic        valid;
  logic        ready;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (output valid, output addr_high, output addr_low, input ready);
  modport sink   (input valid, input addr_high, input addr_low, output ready);
endinterface

>>> rtl/i6t_char_if.sv
interface i6t_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

>>> rtl/ipv6_address_to_text_unit.sv
// channel  role  payload                    per request
// addr     sink  addr_high[63:0] addr_low   one 128-bit address
// text     src   text_char[6:0] last_char   one character of its text
//
// an address is captured, then the zero-run search runs, then its text leaves
// one character a cycle while text is not stalled: 2 to 39 characters in all.
// the rate is set by the single output register.
// addr.ready is high only while no address is being expanded.
// a stall on text holds the controller; rst is synchronous and clears state.
module ipv6_address_to_text_unit (
  input logic          clk,
  input logic          rst,
  i6t_addr_if.sink     addr,
  i6t_char_if.source   text
);

  i6t_pkg::cmd_t    cmd;
  i6t_pkg::status_t status;

  i6t_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (addr.valid),
    .in_ready (addr.ready),
    .status   (status),
    .cmd      (cmd)
  );

  i6t_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .addr_high (addr.addr_high),
    .addr_low  (addr.addr_low),
    .cmd       (cmd),
    .status    (status),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .text_char (text.text_char),
    .last_char (text.last_char)
  );

endmodule

>>> rtl/i6t_datapath.sv
module i6t_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         addr_high,
  input  logic [63:0]         addr_low,
  input  i6t_pkg::cmd_t       cmd,
  output i6t_pkg::status_t    status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          text_char,
  output logic                last_char
);

  logic [127:0] addr;
  logic [i6t_pkg::GROUP_BITS-1:0] grp [i6t_pkg::GROUPS];
  logic [i6t_pkg::GROUPS-1:0] zero;
  logic [2:0] g;
  logic [1:0] dig;
  logic       run_valid;
  logic [2:0] run_start;
  logic [3:0] run_end;

  logic [3:0] best_len;
  logic [2:0] best_start;
  logic       best_found;
  logic [3:0] cur_len;
  logic [2:0] cur_start;
  logic [3:0] best_end;

  logic [2:0] g_next;
  logic [1:0] dig_next;
  logic [i6t_pkg::GROUP_BITS-1:0] cur_grp;
  logic [i6t_pkg::GROUP_BITS-1:0] shifted;
  logic [3:0] nibble;
  logic       out_free;

  // address capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= {addr_high, addr_low};
    end
  end

  // split into groups, group 0 at the top
  always_comb begin
    for (int i = 0; i < i6t_pkg::GROUPS; i++) begin
      grp[i]  = addr[(i6t_pkg::GROUPS-1-i)*i6t_pkg::GROUP_BITS +: i6t_pkg::GROUP_BITS];
      zero[i] = (grp[i] == '0);
    end
  end

  // first longest zero run of two or more groups
  always_comb begin
    best_len   = 4'd1;
    best_start = 3'd0;
    best_found = 1'b0;
    cur_len    = 4'd0;
    cur_start  = 3'd0;
    for (int i = 0; i < i6t_pkg::GROUPS; i++) begin
      if (zero[i]) begin
        if (cur_len == 4'd0) begin
          cur_start = i[2:0];
        end
        cur_len = cur_len + 4'd1;
        if (cur_len > best_len) begin
          best_len   = cur_len;
          best_start = cur_start;
          best_found = 1'b1;
        end
      end else begin
        cur_len = 4'd0;
      end
    end
    best_end = {1'b0, best_start} + best_len;
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      run_valid <= best_found;
      run_start <= best_start;
      run_end   <= best_end;
    end
  end

  // group and digit position
  always_comb begin
    case (cmd.step)
      i6t_pkg::STEP_FIRST: g_next = 3'd0;
      i6t_pkg::STEP_GROUP: g_next = g + 3'd1;
      i6t_pkg::STEP_SKIP:  g_next = run_end[2:0];
      default:             g_next = g;
    endcase
    dig_next = i6t_pkg::lead_digit(grp[g_next]);
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      i6t_pkg::STEP_FIRST, i6t_pkg::STEP_GROUP, i6t_pkg::STEP_SKIP: begin
        g   <= g_next;
        dig <= dig_next;
      end
      i6t_pkg::STEP_DIGIT: begin
        dig <= dig - 2'd1;
      end
      default: begin
      end
    endcase
  end

  // current nibble
  always_comb begin
    cur_grp = grp[g];
    shifted = cur_grp >> {dig, 2'b00};
    nibble  = shifted[3:0];
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != i6t_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != i6t_pkg::EMIT_NONE) begin
      text_char <= (cmd.emit == i6t_pkg::EMIT_DIGIT) ? i6t_pkg::hex_char(nibble)
                                                     : i6t_pkg::CHAR_COLON;
      last_char <= cmd.last;
    end
  end

  // status to the controller
  always_comb begin
    status.out_free    = out_free;
    status.at_run      = run_valid && (g == run_start);
    status.last_digit  = (dig == 2'd0);
    status.final_group = (g == 3'(i6t_pkg::GROUPS - 1));
    status.need_colon  = !status.final_group &&
                         !(run_valid && (({1'b0, g} + 4'd1) == {1'b0, run_start}));
    status.run_to_end  = (run_end == 4'(i6t_pkg::GROUPS));
  end

endmodule

>>> rtl/i6t_ctrl.sv
module i6t_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  i6t_pkg::status_t status,
  output i6t_pkg::cmd_t    cmd
);

  i6t_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i6t_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.search = 1'b0;
    cmd.emit   = i6t_pkg::EMIT_NONE;
    cmd.last   = 1'b0;
    cmd.step   = i6t_pkg::STEP_HOLD;
    case (state)
      i6t_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = i6t_pkg::ST_SEARCH;
        end
      end
      i6t_pkg::ST_SEARCH: begin
        cmd.search = 1'b1;
        cmd.step   = i6t_pkg::STEP_FIRST;
        state_next = i6t_pkg::ST_DIGITS;
      end
      i6t_pkg::ST_DIGITS: begin
        if (status.out_free) begin
          if (status.at_run) begin
            cmd.emit   = i6t_pkg::EMIT_COLON;
            state_next = i6t_pkg::ST_DCOLON;
          end else begin
            cmd.emit = i6t_pkg::EMIT_DIGIT;
            if (!status.last_digit) begin
              cmd.step = i6t_pkg::STEP_DIGIT;
            end else if (status.final_group) begin
              cmd.last   = 1'b1;
              state_next = i6t_pkg::ST_IDLE;
            end else if (status.need_colon) begin
              state_next = i6t_pkg::ST_COLON;
            end else begin
              // next group opens the zero run
              cmd.step = i6t_pkg::STEP_GROUP;
            end
          end
        end
      end
      i6t_pkg::ST_COLON: begin
        if (status.out_free) begin
          cmd.emit   = i6t_pkg::EMIT_COLON;
          cmd.step   = i6t_pkg::STEP_GROUP;
          state_next = i6t_pkg::ST_DIGITS;
        end
      end
      i6t_pkg::ST_DCOLON: begin
        if (status.out_free) begin
          cmd.emit = i6t_pkg::EMIT_COLON;
          if (status.run_to_end) begin
            cmd.last   = 1'b1;
            state_next = i6t_pkg::ST_IDLE;
          end else begin
            cmd.step   = i6t_pkg::STEP_SKIP;
            state_next = i6t_pkg::ST_DIGITS;
          end
        end
      end
      default: begin
        state_next = i6t_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/i6t_checker.sv
module i6t_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] text_char,
  input logic       last_char
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last_char))
    else $error("stalled character changed");

  // a new address is not taken straight after one was accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("address taken while busy");

  // only hex digits and colons leave the block
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((text_char >= 7'h30 && text_char <= 7'h39) ||
                   (text_char >= 7'h61 && text_char <= 7'h66) ||
                   (text_char == 7'h3A)))
    else $error("character outside text set");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ipv6_address_to_text_unit i6t_checker u_i6t_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (addr.valid),
  .in_ready  (addr.ready),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .text_char (text.text_char),
  .last_char (text.last_char)
);

>>> sim/ipv6_address_to_text_unit_tb.sv
`timescale 1ns / 100ps

module ipv6_address_to_text_unit_tb;

  localparam int RANDOM_ADDRS = 360;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } due_char_t;

  logic clk = 1'b0;
  logic rst;

  i6t_addr_if addr_bus ();
  i6t_char_if text_bus ();

  ipv6_address_to_text_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .addr (addr_bus),
    .text (text_bus)
  );

  logic [127:0] addr_backlog [$];
  due_char_t    text_due [$];
  int           addr_total;
  int           addrs_taken = 0;
  int           mismatches = 0;
  bit           addr_taken = 1'b0;
  int           send_gap = 0;
  int           send_calm = 0;
  int           stall_left = 0;
  int           sink_calm = 0;

  always #5 clk = ~clk;

  // one line per mismatch, and a running count
  task automatic flag_error(input string what);
    $display("%0t: mismatch, %s", $time, what);
    mismatches++;
  endtask

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(inout int calm_left);
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // canonical text of one address, queued with the flag on its last character
  function automatic void format_address(input logic [127:0] addr);
    logic [15:0] grp [i6t_pkg::GROUPS];
    logic [6:0]  line [$];
    logic [3:0]  nib;
    int          best_start;
    int          best_len;
    int          cur_start;
    int          cur_len;
    int          g;
    int          s;
    bit          started;
    best_start = -1;
    best_len   = 1;
    cur_start  = 0;
    cur_len    = 0;
    // first longest run of two or more zero groups
    for (g = 0; g < i6t_pkg::GROUPS; g++) begin
      grp[g] = addr[127 - i6t_pkg::GROUP_BITS*g -: i6t_pkg::GROUP_BITS];
      if (grp[g] == '0) begin
        if (cur_len == 0) cur_start = g;
        cur_len++;
        if (cur_len > best_len) begin
          best_len   = cur_len;
          best_start = cur_start;
        end
      end else begin
        cur_len = 0;
      end
    end
    // groups without leading zeros, the chosen run as a double colon
    g = 0;
    while (g < i6t_pkg::GROUPS) begin
      if (g == best_start) begin
        line.push_back(i6t_pkg::CHAR_COLON);
        line.push_back(i6t_pkg::CHAR_COLON);
        g += best_len;
      end else begin
        started = 1'b0;
        for (s = i6t_pkg::NIBBLES - 1; s >= 0; s--) begin
          nib = grp[g][4*s +: 4];
          if (nib != 4'd0 || started || s == 0) begin
            line.push_back(nib >= 4'd10 ? i6t_pkg::CHAR_A + 7'(nib - 4'd10)
                                        : i6t_pkg::CHAR_ZERO + 7'(nib));
            started = 1'b1;
          end
        end
        if (g < i6t_pkg::GROUPS - 1 && g + 1 != best_start) begin
          line.push_back(i6t_pkg::CHAR_COLON);
        end
        g++;
      end
    end
    foreach (line[i]) text_due.push_back('{line[i], i == line.size() - 1});
  endfunction

  // request driver, holds each address until it is taken
  always @(negedge clk) begin
    if (rst) begin
      addr_bus.valid <= 1'b0;
    end else if (!addr_bus.valid || addr_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        addr_bus.valid     <= 1'b0;
        addr_bus.addr_high <= {$urandom, $urandom};
        addr_bus.addr_low  <= {$urandom, $urandom};
      end else if (addr_backlog.size() > 0) begin
        {addr_bus.addr_high, addr_bus.addr_low} <= addr_backlog.pop_front();
        addr_bus.valid <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        addr_bus.valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      text_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      text_bus.ready <= 1'b1;
      stall_left = pick_gap(sink_calm);
    end
  end

  // monitor: predict on each request, check each character in order
  always @(posedge clk) begin
    addr_taken <= !rst && addr_bus.valid && addr_bus.ready;
    if (!rst) begin
      if (addr_bus.valid && addr_bus.ready) begin
        format_address({addr_bus.addr_high, addr_bus.addr_low});
        addrs_taken++;
      end
      if (text_bus.valid && text_bus.ready) begin
        if (text_due.size() == 0) begin
          flag_error($sformatf("character 0x%02h with nothing outstanding", text_bus.text_char));
        end else begin
          if (text_bus.text_char !== text_due[0].ch) begin
            flag_error($sformatf("text_char 0x%02h, predicted 0x%02h",
                                 text_bus.text_char, text_due[0].ch));
          end
          if (text_bus.last_char !== text_due[0].last) begin
            flag_error($sformatf("last_char %b, predicted %b",
                                 text_bus.last_char, text_due[0].last));
          end
          void'(text_due.pop_front());
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int           i;
    int           g;
    int           style;
    int           zero_pct;
    int           nibs;
    int           run_start;
    int           run_len;
    logic [127:0] word;
    logic [15:0]  grp;
    rst                = 1'b1;
    addr_bus.valid     = 1'b0;
    addr_bus.addr_high = '0;
    addr_bus.addr_low  = '0;
    text_bus.ready     = 1'b0;

    // all zero, all ones, runs at either edge
    addr_backlog.push_back(128'h0000_0000_0000_0000_0000_0000_0000_0000);
    addr_backlog.push_back(128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff);
    addr_backlog.push_back(128'h0000_0000_0000_0000_0000_0000_0000_0001);
    addr_backlog.push_back(128'h0001_0000_0000_0000_0000_0000_0000_0000);
    addr_backlog.push_back(128'h0001_0000_0000_0000_0000_0000_0000_0001);
    addr_backlog.push_back(128'h0001_0001_0001_0001_0001_0001_0000_0000);
    // equal runs, earlier one wins; a later longer run wins
    addr_backlog.push_back(128'h0001_0000_0000_0001_0000_0000_0001_0001);
    addr_backlog.push_back(128'h0000_0000_0001_0000_0000_0001_0000_0000);
    addr_backlog.push_back(128'h0001_0000_0000_0001_0000_0000_0000_0001);
    // lone zero groups stay as a single digit
    addr_backlog.push_back(128'h0001_0000_0001_0001_0001_0001_0001_0001);
    addr_backlog.push_back(128'h0000_0001_0001_0001_0001_0001_0001_0000);
    addr_backlog.push_back(128'h0000_0001_0000_0001_0000_0001_0000_0001);
    // leading and inner zero digits, every hex letter
    addr_backlog.push_back(128'h000f_00f0_0f00_f000_1234_abcd_09af_8000);
    addr_backlog.push_back(128'h1000_0100_0010_0001_0f0f_f0f0_a0b0_00ce);
    addr_backlog.push_back(128'h2001_0db8_0000_0000_0000_ff00_0042_8329);
    addr_backlog.push_back(128'h0000_0000_0000_0000_0000_ffff_c000_0280);
    // alternating bit patterns
    addr_backlog.push_back(128'h5555_5555_5555_5555_aaaa_aaaa_aaaa_aaaa);
    addr_backlog.push_back(128'haaaa_aaaa_aaaa_aaaa_5555_5555_5555_5555);

    // random addresses, mostly built group by group with a chosen zero density
    for (i = 0; i < RANDOM_ADDRS; i++) begin
      style = $urandom_range(0, 9);
      if (style < 2) begin
        word = {$urandom, $urandom, $urandom, $urandom};
      end else begin
        zero_pct = 20 * $urandom_range(0, 4);
        word = '0;
        for (g = 0; g < i6t_pkg::GROUPS; g++) begin
          if ($urandom_range(0, 99) < zero_pct) begin
            grp = '0;
          end else begin
            nibs = $urandom_range(1, i6t_pkg::NIBBLES);
            grp  = 16'($urandom) & 16'((32'h1 << (4*nibs)) - 1);
          end
          word = {word[111:0], grp};
        end
        // force a zero run of random place and length
        if (style == 9) begin
          run_start = $urandom_range(0, i6t_pkg::GROUPS - 2);
          run_len   = $urandom_range(2, i6t_pkg::GROUPS - run_start);
          for (g = run_start; g < run_start + run_len; g++) begin
            word[127 - i6t_pkg::GROUP_BITS*g -: i6t_pkg::GROUP_BITS] = '0;
          end
        end
      end
      addr_backlog.push_back(word);
    end
    addr_total = addr_backlog.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every request to be taken and every character to arrive
    while (addrs_taken < addr_total || text_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // upper bound well past the slowest legal run
  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
